### hdl/imu_bias_average_and_correct_assert.svh
// Assertion macros for the IMU bias averaging block.
// Used by the top level; relies on clk and arst_n in the including scope.
`ifndef IMU_BIAS_AVERAGE_AND_CORRECT_ASSERT_SVH
`define IMU_BIAS_AVERAGE_AND_CORRECT_ASSERT_SVH
`ifndef SYNTH
`define IBAC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define IBAC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define IBAC_ASSERT(lbl, prop, msg)
`define IBAC_NEVER(lbl, cond, msg)
`endif
`endif

### hdl/ibac_pkg.sv
// Shared types and constants for the IMU bias averaging block.
// No dependencies.
`default_nettype none
package ibac_pkg;
	localparam int SAMPLE_LIMIT = 65535;
	localparam int CNT_W = 16;
	localparam int SUM_W = 33;
	localparam int ELAPSED_W = 32;
	localparam int CALIB_W = 26;
	localparam int ZMIN_W = 15;
	localparam int NUM_LANES = 6;
	localparam int DIV_STEPS = SUM_W;
	localparam int STEP_W = $clog2(DIV_STEPS);
	localparam logic signed [15:0] ONE_G_Q14 = 16'sd16384;

	localparam logic CFG_CALIB_TIME = 1'b0;
	localparam logic CFG_GRAVITY_Z_MIN = 1'b1;

	typedef logic signed [15:0] axis_t;

	typedef struct packed {
		logic acc;
		logic load;
		logic step;
		logic finish;
	} lane_ctl_t;

	typedef enum logic [2:0] {
		S_CAL,
		S_LOAD,
		S_DIV,
		S_FIN,
		S_MRG,
		S_EMIT,
		S_RUN
	} state_t;
endpackage
`default_nettype wire

### hdl/ibac_lane.sv
// One axis lane: running sum and a bit-serial divider that forms the average.
// Depends on ibac_pkg.
`default_nettype none
module ibac_lane
	import ibac_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire lane_ctl_t        ctl,
	input  wire axis_t            sample,
	input  wire logic [CNT_W-1:0] divisor,
	output axis_t                 avg
);
	logic signed [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0]        quo_q;
	logic [CNT_W-1:0]        rem_q;
	logic                    neg_q;
	axis_t                   avg_q;
	logic [CNT_W:0]          rem_sh;
	logic                    fits;
	logic [CNT_W:0]          rem_sub;

	assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
	assign fits    = rem_sh >= {1'b0, divisor};
	assign rem_sub = rem_sh - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			avg_q <= '0;
		end else begin
			if (ctl.acc) begin
				sum_q <= sum_q + {{(SUM_W-16){sample[15]}}, sample};
			end
			if (ctl.finish) begin
				avg_q <= neg_q ? -axis_t'(quo_q[15:0]) : axis_t'(quo_q[15:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			neg_q <= sum_q[SUM_W-1];
			quo_q <= sum_q[SUM_W-1] ? -sum_q : sum_q;
			rem_q <= '0;
		end else if (ctl.step) begin
			quo_q <= {quo_q[SUM_W-2:0], fits};
			rem_q <= fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
		end
	end

	assign avg = avg_q;
endmodule
`default_nettype wire

### hdl/ibac_merge.sv
// Merge stage: takes the accelerometer lane averages and holds the gravity vector,
// falling back to one g on Z when the averaged Z is below threshold. Depends on ibac_pkg.
`default_nettype none
module ibac_merge
	import ibac_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              commit,
	input  wire logic [ZMIN_W-1:0] z_min,
	input  wire axis_t             accel_avg [3],
	output axis_t                  gravity [3]
);
	axis_t grav_q [3];
	logic  below;

	assign below = $signed({accel_avg[2][15], accel_avg[2]}) < $signed({2'b00, z_min});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				grav_q[i] <= '0;
			end
		end else if (commit) begin
			if (below) begin
				grav_q[0] <= '0;
				grav_q[1] <= '0;
				grav_q[2] <= ONE_G_Q14;
			end else begin
				for (int i = 0; i < 3; i++) begin
					grav_q[i] <= accel_avg[i];
				end
			end
		end
	end

	assign gravity = grav_q;
endmodule
`default_nettype wire

### hdl/imu_bias_average_and_correct.sv
// IMU bias averaging and correction, top level. Calibrating: one transaction per cycle, no result
// while calibration time is left. The closing calibration sample stalls the input through load,
// 33 divider steps in six parallel lanes, finish, merge and emit; its result is loaded at emit.
// Calibrated: one transaction per cycle while the output is not stalled, registered on acceptance.
// Reset clears sums, count, elapsed time, averages and gravity, and restarts calibration.
`default_nettype none
`include "imu_bias_average_and_correct_assert.svh"
module imu_bias_average_and_correct
	import ibac_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [CALIB_W-1:0] cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire axis_t              accel_x,
	input  wire axis_t              accel_y,
	input  wire axis_t              accel_z,
	input  wire axis_t              gyro_x,
	input  wire axis_t              gyro_y,
	input  wire axis_t              gyro_z,
	input  wire logic [15:0]        delta_time_us,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [16:0]      gyro_fixed_x,
	output logic signed [16:0]      gyro_fixed_y,
	output logic signed [16:0]      gyro_fixed_z,
	output axis_t                   gravity_x,
	output axis_t                   gravity_y,
	output axis_t                   gravity_z
);
	state_t                 state_q, state_d;
	logic [CALIB_W-1:0]     calib_q;
	logic [ZMIN_W-1:0]      zmin_q;
	logic [CNT_W-1:0]       count_q, count_d;
	logic [ELAPSED_W-1:0]   elapsed_q, elapsed_d;
	logic [ELAPSED_W:0]     elapsed_sum;
	logic [STEP_W-1:0]      step_q;
	axis_t                  gyro_hold_q [3];
	logic                   out_valid_q;
	logic signed [16:0]     fix_q [3];
	axis_t                  grav_out_q [3];

	logic                   accept;
	logic                   time_left;
	logic                   finish_cal;
	logic                   acc_en, load_en, step_en, fin_en, commit_en, out_load, use_hold;
	lane_ctl_t              ctl;
	axis_t                  lane_in [NUM_LANES];
	axis_t                  lane_avg [NUM_LANES];
	axis_t                  accel_avg [3];
	axis_t                  gravity [3];
	axis_t                  gyro_live [3];
	axis_t                  gyro_src [3];

	assign gyro_live[0] = gyro_x;
	assign gyro_live[1] = gyro_y;
	assign gyro_live[2] = gyro_z;
	assign lane_in[0] = accel_x;
	assign lane_in[1] = accel_y;
	assign lane_in[2] = accel_z;
	assign lane_in[3] = gyro_x;
	assign lane_in[4] = gyro_y;
	assign lane_in[5] = gyro_z;

	assign in_stall = ((state_q != S_CAL) && (state_q != S_RUN)) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;

	assign time_left   = elapsed_q < {{(ELAPSED_W-CALIB_W){1'b0}}, calib_q};
	assign count_d     = (count_q < CNT_W'(SAMPLE_LIMIT)) ? count_q + 1'b1 : count_q;
	assign elapsed_sum = {1'b0, elapsed_q} + {{(ELAPSED_W+1-16){1'b0}}, delta_time_us};
	assign elapsed_d   = elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];
	assign finish_cal  = !((elapsed_d < {{(ELAPSED_W-CALIB_W){1'b0}}, calib_q})
		&& (count_d < CNT_W'(SAMPLE_LIMIT)));

	always_comb begin
		state_d   = state_q;
		acc_en    = 1'b0;
		load_en   = 1'b0;
		step_en   = 1'b0;
		fin_en    = 1'b0;
		commit_en = 1'b0;
		out_load  = 1'b0;
		use_hold  = 1'b0;
		unique case (state_q)
			S_CAL: begin
				if (accept) begin
					if (!time_left) begin
						out_load = 1'b1;
						state_d  = S_RUN;
					end else begin
						acc_en = 1'b1;
						if (finish_cal) begin
							state_d = S_LOAD;
						end
					end
				end
			end
			S_LOAD: begin
				load_en = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				step_en = 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				fin_en  = 1'b1;
				state_d = S_MRG;
			end
			S_MRG: begin
				commit_en = 1'b1;
				state_d   = S_EMIT;
			end
			S_EMIT: begin
				out_load = 1'b1;
				use_hold = 1'b1;
				state_d  = S_RUN;
			end
			S_RUN: begin
				out_load = accept;
			end
			default: state_d = S_CAL;
		endcase
	end

	assign ctl = '{acc: acc_en, load: load_en, step: step_en, finish: fin_en};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CAL;
			calib_q     <= CALIB_W'(1000000);
			zmin_q      <= ZMIN_W'(16302);
			count_q     <= '0;
			elapsed_q   <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CALIB_TIME:    calib_q <= cfg_data;
					CFG_GRAVITY_Z_MIN: zmin_q  <= cfg_data[ZMIN_W-1:0];
					default: ;
				endcase
			end
			if (acc_en) begin
				count_q   <= count_d;
				elapsed_q <= elapsed_d;
			end
			step_q <= step_en ? step_q + 1'b1 : '0;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			gyro_src[i]  = use_hold ? gyro_hold_q[i] : gyro_live[i];
			accel_avg[i] = lane_avg[i];
		end
	end

	always_ff @(posedge clk) begin
		if (acc_en) begin
			gyro_hold_q <= gyro_live;
		end
		if (out_load) begin
			for (int i = 0; i < 3; i++) begin
				fix_q[i] <= {gyro_src[i][15], gyro_src[i]}
					- {lane_avg[3+i][15], lane_avg[3+i]};
				grav_out_q[i] <= gravity[i];
			end
		end
	end

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		ibac_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.sample  (lane_in[g]),
			.divisor (count_q),
			.avg     (lane_avg[g])
		);
	end

	ibac_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (commit_en),
		.z_min     (zmin_q),
		.accel_avg (accel_avg),
		.gravity   (gravity)
	);

	assign out_valid    = out_valid_q;
	assign gyro_fixed_x = fix_q[0];
	assign gyro_fixed_y = fix_q[1];
	assign gyro_fixed_z = fix_q[2];
	assign gravity_x    = grav_out_q[0];
	assign gravity_y    = grav_out_q[1];
	assign gravity_z    = grav_out_q[2];

	`IBAC_ASSERT(a_div_holds_input, (state_q == S_DIV) |-> in_stall, "input taken during divide")
	`IBAC_NEVER(a_no_result_cal, (state_q == S_CAL) && out_valid_q, "result while calibrating")
	`IBAC_ASSERT(a_emit_result, (state_q == S_EMIT) |=> out_valid_q, "calibration result missing")
	`IBAC_ASSERT(a_div_enter, $rose(state_q == S_DIV) |-> $past(state_q == S_LOAD), "divide skipped load")
endmodule
`default_nettype wire
